// File: hdl/abrt_pkg.sv
package abrt_pkg;

  localparam int unsigned QueueDepthDef = 8;
  localparam logic [19:0] AckTimeoutRst = 20'd10000;
  localparam logic [3:0]  MaxRetriesRst = 4'd5;
  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

  // input kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;

  // result kinds
  localparam logic [1:0] RES_STATUS = 2'd0;
  localparam logic [1:0] RES_BATCH  = 2'd1;
  localparam logic [1:0] RES_APPEND = 2'd2;

  // register indexes
  localparam logic [0:0] REG_ACK_TIMEOUT = 1'd0;
  localparam logic [0:0] REG_MAX_RETRIES = 1'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] now_ms;
    logic        link_up;
    logic        send_ok;
    logic        save_ok;
    logic [31:0] ack_id;
    logic        ack_final;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] batch_id;
    logic        batch_last;
    logic        is_retry;
    logic [31:0] record_id;
    logic        append_kept;
    logic        dropped_oldest;
    logic [3:0]  pending_count;
    logic        in_flight;
    logic [3:0]  retries_done;
    logic        awaiting_reconnect;
  } out_item_t;

endpackage

// File: hdl/acked_batch_retransmit_tracker.sv
// acked batch retransmit tracker
// usage: drive a transaction on in_item with start high; it is taken at a
// rising edge where busy is low. cfg_we writes cfg_wdata to register cfg_idx
// (0 ack timeout, 1 max retries); user must write only while idle; not enforced.
// results leave on out_item, one cycle each, marked by out_valid; a batch
// send gives one result per queued id, batch_last on the last one.
// the steps from acceptance to the last result run on one shared 32-bit
// comparator that a sequencer walks over the pending and in-flight queues:
//   status-only tick: status result; first send: copy ids, then one id a cycle
//   retry: each in-flight id is searched from the head of the pending
//   queue, then one id a cycle
//   ack: search and shift, mark, compact, status
//   append: one result, after shifting out the oldest id when full
// busy stays high from acceptance until the last result has been shown; the
// next transaction can be taken once busy has fallen.
// reset: queues empty, next id 1, timeout 10000 ms, max retries 5.
// the receiver cannot stall; results are never held.
module acked_batch_retransmit_tracker #(
  parameter int unsigned QUEUE_DEPTH = abrt_pkg::QueueDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  abrt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output abrt_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [19:0]         cfg_wdata
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CHKFL  = 10'b0000000010, // unused; the flight walk is done in S_CHKPD
    S_CHKPD  = 10'b0000000100,
    S_COPY   = 10'b0000001000, // copy pending to flight
    S_SEND   = 10'b0000010000,
    S_SHIFT  = 10'b0000100000, // remove pending entry at idx, shift down
    S_ASRCH  = 10'b0001000000, // ack search pending
    S_AMARK  = 10'b0010000000, // ack mark flight
    S_ACOMP  = 10'b0100000000, // compact flight
    S_STAT   = 10'b1000000000
  } state_t;

  state_t state_r;

  logic [31:0] pend_r [QUEUE_DEPTH];
  logic [31:0] flt_r  [QUEUE_DEPTH];
  logic [CW-1:0] plen_r, flen_r;
  logic [31:0] next_id_r;
  logic        factive_r, rwait_r, plink_r, removed_r;
  logic [3:0]  retry_r;
  logic [47:0] dl_r;
  logic [QUEUE_DEPTH-1:0] marks_r;
  logic [19:0] tmo_r;
  logic [3:0]  maxr_r;

  abrt_pkg::in_item_t in_r;
  logic [CW-1:0] i_r, j_r, k_r;   // walk counters
  logic          isretry_r, ret_stat_r; // after shift: go to status result
  logic          append_r, kept_r, dropped_r;
  logic [31:0]   aid_r;

  // shared compare unit
  logic [31:0] cmp_a, cmp_b;
  logic        cmp_eq;
  assign cmp_eq = (cmp_a == cmp_b);

  // saturating deadline add
  function automatic logic [47:0] sat_add(input logic [47:0] now,
                                          input logic [19:0] tmo,
                                          input logic [3:0] sh);
    logic [67:0] span;
    logic [68:0] sum;
    begin
      span = {48'd0, tmo} << sh;
      sum  = {21'd0, now} + {1'b0, span};
      sat_add = (sum > {21'd0, abrt_pkg::TimeMax}) ? abrt_pkg::TimeMax : sum[47:0];
    end
  endfunction

  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_r)
      S_CHKPD: begin
        cmp_a = flt_r[i_r[IW-1:0]];
        cmp_b = pend_r[j_r[IW-1:0]];
      end
      S_ASRCH: begin
        cmp_a = pend_r[i_r[IW-1:0]];
        cmp_b = in_r.ack_id;
      end
      S_AMARK: begin
        cmp_a = flt_r[i_r[IW-1:0]];
        cmp_b = in_r.ack_id;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // output composition
  always_comb begin
    out_valid = 1'b0;
    out_item  = '0;
    out_item.pending_count      = 4'(plen_r);
    out_item.in_flight          = factive_r;
    out_item.retries_done       = retry_r;
    out_item.awaiting_reconnect = rwait_r;
    out_item.batch_last         = 1'b1;
    if (state_r == S_SEND) begin
      out_valid = 1'b1;
      out_item.result_kind = abrt_pkg::RES_BATCH;
      out_item.batch_id    = flt_r[i_r[IW-1:0]];
      out_item.batch_last  = (i_r + 1'b1 == flen_r);
      out_item.is_retry    = isretry_r;
    end else if (state_r == S_STAT) begin
      out_valid = 1'b1;
      if (append_r) begin
        out_item.result_kind    = abrt_pkg::RES_APPEND;
        out_item.record_id      = aid_r;
        out_item.append_kept    = kept_r;
        out_item.dropped_oldest = dropped_r;
      end else begin
        out_item.result_kind = abrt_pkg::RES_STATUS;
      end
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r  <= abrt_pkg::AckTimeoutRst;
      maxr_r <= abrt_pkg::MaxRetriesRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        abrt_pkg::REG_ACK_TIMEOUT: tmo_r  <= cfg_wdata;
        abrt_pkg::REG_MAX_RETRIES: maxr_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      plen_r    <= '0;
      flen_r    <= '0;
      next_id_r <= 32'd1;
      factive_r <= 1'b0;
      rwait_r   <= 1'b0;
      plink_r   <= 1'b0;
      removed_r <= 1'b0;
      retry_r   <= '0;
      dl_r      <= '0;
      marks_r   <= '0;
      append_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            in_r     <= in_item;
            append_r <= 1'b0;
            i_r      <= '0;
            j_r      <= '0;
            k_r      <= '0;
            case (in_item.kind)
              abrt_pkg::KIND_TICK: begin
                logic fa;
                logic rw;
                logic [CW-1:0] fl;
                fa = factive_r;
                rw = rwait_r;
                fl = flen_r;
                if (in_item.link_up != plink_r) begin
                  plink_r   <= in_item.link_up;
                  factive_r <= 1'b0;
                  retry_r   <= '0;
                  flen_r    <= '0;
                  dl_r      <= '0;
                  marks_r   <= '0;
                  fa = 1'b0;
                  fl = '0;
                  if (in_item.link_up) begin
                    rwait_r <= 1'b0;
                    rw = 1'b0;
                  end
                end
                state_r <= S_STAT;
                if (in_item.link_up) begin
                  if (fa) begin
                    if (in_item.now_ms >= dl_r) begin
                      if (retry_r >= maxr_r) begin
                        factive_r <= 1'b0;
                        rwait_r   <= 1'b1;
                        flen_r    <= '0;
                        marks_r   <= '0;
                      end else if (fl == '0) begin
                        factive_r <= 1'b0;
                        marks_r   <= '0;
                      end else begin
                        state_r <= S_CHKPD;
                      end
                    end
                  end else if (plen_r != '0 && !rw && in_item.send_ok) begin
                    state_r <= S_COPY;
                  end
                end
              end
              abrt_pkg::KIND_APPEND: begin
                append_r  <= 1'b1;
                aid_r     <= next_id_r;
                kept_r    <= in_item.save_ok;
                dropped_r <= (32'(plen_r) >= QUEUE_DEPTH);
                if (in_item.save_ok)
                  next_id_r <= (next_id_r == '1) ? 32'd1 : next_id_r + 32'd1;
                if (32'(plen_r) >= QUEUE_DEPTH) begin
                  // drop oldest, then append at the end if kept
                  ret_stat_r <= 1'b1;
                  state_r    <= S_SHIFT;
                end else begin
                  if (in_item.save_ok) begin
                    pend_r[plen_r[IW-1:0]] <= next_id_r;
                    plen_r <= plen_r + 1'b1;
                  end
                  state_r <= S_STAT;
                end
              end
              abrt_pkg::KIND_ACK: begin
                state_r <= S_ASRCH;
              end
              default: state_r <= S_STAT;
            endcase
          end
        end

        // every flight id must still be pending
        S_CHKPD: begin
          if (j_r >= plen_r) begin
            factive_r <= 1'b0;
            flen_r    <= '0;
            marks_r   <= '0;
            state_r   <= S_STAT;
          end else if (cmp_eq) begin
            j_r <= '0;
            if (i_r + 1'b1 == flen_r) begin
              i_r <= '0;
              if (!in_r.send_ok) begin
                state_r <= S_STAT;
              end else begin
                retry_r   <= retry_r + 4'd1;
                dl_r      <= sat_add(in_r.now_ms, tmo_r, retry_r + 4'd1);
                isretry_r <= 1'b1;
                state_r   <= S_SEND;
              end
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end

        S_COPY: begin
          flt_r[i_r[IW-1:0]] <= pend_r[i_r[IW-1:0]];
          if (i_r + 1'b1 == plen_r) begin
            flen_r    <= plen_r;
            factive_r <= 1'b1;
            retry_r   <= '0;
            marks_r   <= '0;
            dl_r      <= sat_add(in_r.now_ms, tmo_r, 4'd0);
            isretry_r <= 1'b0;
            i_r       <= '0;
            state_r   <= S_SEND;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end

        S_SEND: begin
          if (i_r + 1'b1 == flen_r) state_r <= S_IDLE;
          else i_r <= i_r + 1'b1;
        end

        // remove entry j_r from pending by shifting down
        S_SHIFT: begin
          if (j_r + 1'b1 < plen_r) begin
            pend_r[j_r[IW-1:0]] <= pend_r[IW'(j_r + 1'b1)];
            j_r <= j_r + 1'b1;
          end else begin
            if (append_r && kept_r) begin
              pend_r[j_r[IW-1:0]] <= aid_r;
              state_r <= S_STAT;
            end else begin
              plen_r  <= plen_r - 1'b1;
              i_r     <= '0;
              state_r <= ret_stat_r ? S_STAT : S_AMARK;
            end
          end
        end

        S_ASRCH: begin
          if (i_r >= plen_r) begin
            i_r     <= '0;
            state_r <= S_AMARK;
          end else if (cmp_eq) begin
            removed_r  <= 1'b1;
            j_r        <= i_r;
            ret_stat_r <= 1'b0;
            state_r    <= S_SHIFT;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end

        S_AMARK: begin
          if (i_r >= flen_r) begin
            i_r <= '0;
            k_r <= '0;
            if (!in_r.ack_final) state_r <= S_STAT;
            else if (removed_r && factive_r) state_r <= S_ACOMP;
            else begin
              marks_r   <= '0;
              removed_r <= 1'b0;
              state_r   <= S_STAT;
            end
          end else begin
            if (cmp_eq) marks_r[i_r[IW-1:0]] <= 1'b1;
            i_r <= i_r + 1'b1;
          end
        end

        S_ACOMP: begin
          if (i_r >= flen_r) begin
            flen_r <= k_r;
            if (k_r == '0) begin
              factive_r <= 1'b0;
              retry_r   <= '0;
              dl_r      <= '0;
            end else begin
              dl_r <= sat_add(in_r.now_ms, tmo_r, 4'd0);
            end
            marks_r   <= '0;
            removed_r <= 1'b0;
            state_r   <= S_STAT;
          end else begin
            if (!marks_r[i_r[IW-1:0]]) begin
              flt_r[k_r[IW-1:0]] <= flt_r[i_r[IW-1:0]];
              k_r <= k_r + 1'b1;
            end
            i_r <= i_r + 1'b1;
          end
        end

        S_STAT: state_r <= S_IDLE;

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
